// File: rtl/segint_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segint_pkg
// Shared defaults, result codes and bounds for the segment intersection block.
// ----------------------------------------------------------------------------
package segint_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [31:0] PT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] PT_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        OUT_CROSS   = 3'd0,
        OUT_OUTSIDE = 3'd1,
        OUT_TOUCH   = 3'd2,
        OUT_OVERLAP = 3'd3,
        OUT_NONE    = 3'd4
    } t_outcome;

endpackage

// File: rtl/segint_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segint_cell
// One restoring division step for the x and y lanes, with pass-through of the
// divisor and the result sideband.
// ----------------------------------------------------------------------------
module segint_cell
    import segint_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    input  logic [2*COORD_BITS+1:0]                i_den,
    input  logic [1:0][2*COORD_BITS+1:0]           i_rem,
    input  logic [1:0][COORD_BITS+FRAC_BITS:0]     i_sr,
    input  logic [1:0][COORD_BITS+FRAC_BITS:0]     i_q,
    input  logic [2*COORD_BITS+68:0]               i_side,
    output logic [2*COORD_BITS+1:0]                o_den,
    output logic [1:0][2*COORD_BITS+1:0]           o_rem,
    output logic [1:0][COORD_BITS+FRAC_BITS:0]     o_sr,
    output logic [1:0][COORD_BITS+FRAC_BITS:0]     o_q,
    output logic [2*COORD_BITS+68:0]               o_side
);

    localparam int DW  = 2*COORD_BITS+2;
    localparam int SRW = COORD_BITS+1+FRAC_BITS;

    logic                    r_valid;
    logic [DW-1:0]           r_den;
    logic [1:0][DW-1:0]      r_rem;
    logic [1:0][SRW-1:0]     r_sr;
    logic [1:0][SRW-1:0]     r_q;
    logic [2*COORD_BITS+68:0] r_side;

    logic [1:0][DW-1:0]      n_rem;
    logic [1:0][SRW-1:0]     n_sr;
    logic [1:0][SRW-1:0]     n_q;

    logic [DW:0]             trial [2];
    logic [1:0]              ge;

    assign o_ready = !r_valid | i_ready;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            trial[l] = {i_rem[l], i_sr[l][SRW-1]};
            ge[l]    = trial[l] >= {1'b0, i_den};
            n_rem[l] = ge[l] ? DW'(trial[l] - {1'b0, i_den}) : DW'(trial[l]);
            n_sr[l]  = i_sr[l] << 1;
            n_q[l]   = {i_q[l][SRW-2:0], ge[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_den  <= i_den;
            r_rem  <= n_rem;
            r_sr   <= n_sr;
            r_q    <= n_q;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_den   = r_den;
    assign o_rem   = r_rem;
    assign o_sr    = r_sr;
    assign o_q     = r_q;
    assign o_side  = r_side;

endmodule

// File: rtl/segint_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segint_front
// Eight-stage front end: differences and ordering, cross products,
// classification, crossing numerators and their magnitudes for the divider.
// ----------------------------------------------------------------------------
module segint_front
    import segint_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [COORD_BITS-1:0]       i_first_start_x,
    input  logic signed [COORD_BITS-1:0]       i_first_start_y,
    input  logic signed [COORD_BITS-1:0]       i_first_end_x,
    input  logic signed [COORD_BITS-1:0]       i_first_end_y,
    input  logic signed [COORD_BITS-1:0]       i_second_start_x,
    input  logic signed [COORD_BITS-1:0]       i_second_start_y,
    input  logic signed [COORD_BITS-1:0]       i_second_end_x,
    input  logic signed [COORD_BITS-1:0]       i_second_end_y,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [2*COORD_BITS+1:0]            o_den,
    output logic [1:0][2*COORD_BITS+1:0]       o_rem,
    output logic [1:0][COORD_BITS+FRAC_BITS:0] o_sr,
    output logic [2*COORD_BITS+68:0]           o_side
);

    localparam int CB  = COORD_BITS;
    localparam int DXW = CB+1;
    localparam int PW  = 2*CB+2;
    localparam int DW  = 2*CB+2;
    localparam int DNW = DW+1;
    localparam int H   = CB+1;
    localparam int QPW = 2*CB+3;
    localparam int NW  = 3*CB+3;
    localparam int MW  = NW-1;
    localparam int SRW = CB+1+FRAC_BITS;
    localparam int CLW = 2*CB+66;
    localparam int SW0 = 2*CB+67;

    typedef enum logic [1:0] {LEX_LT, LEX_EQ, LEX_GT} t_lex;

    function automatic t_lex lex_cmp(input logic signed [CB-1:0] ax,
                                     input logic signed [CB-1:0] ay,
                                     input logic signed [CB-1:0] bx,
                                     input logic signed [CB-1:0] by);
        t_lex res;
        if (ax != bx) begin
            res = (ax < bx) ? LEX_LT : LEX_GT;
        end else if (ay != by) begin
            res = (ay < by) ? LEX_LT : LEX_GT;
        end else begin
            res = LEX_EQ;
        end
        return res;
    endfunction

    function automatic logic [31:0] int_fix(input logic signed [CB-1:0] v);
        logic signed [63:0] w;
        logic [31:0]        res;
        w = 64'(v) <<< FRAC_BITS;
        if (w > 64'sd2147483647) begin
            res = PT_MAX;
        end else if (w < -64'sd2147483648) begin
            res = PT_MIN;
        end else begin
            res = w[31:0];
        end
        return res;
    endfunction

    // flow control
    logic [8:1] r_v;
    logic [8:1] n_v;
    logic [9:1] en;

    assign en[9] = i_ready;
    genvar gk;
    for (gk = 1; gk <= 8; gk++) begin : g_en
        assign en[gk] = !r_v[gk] | en[gk+1];
    end

    always_comb begin
        n_v[1] = en[1] ? i_valid : r_v[1];
        for (int k = 2; k <= 8; k++) begin
            n_v[k] = en[k] ? r_v[k-1] : r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_ready = en[1];
    assign o_valid = r_v[8];

    // stage 1: differences, endpoint ordering
    logic signed [CB-1:0]  x1, y1, x2, y2, x3, y3, x4, y4;
    logic signed [CB-1:0]  lo1x, lo1y, hi1x, hi1y, lo2x, lo2y, hi2x, hi2y;
    logic signed [CB-1:0]  sx, sy, tx, ty;
    t_lex                  cc;

    assign x1 = i_first_start_x;
    assign y1 = i_first_start_y;
    assign x2 = i_first_end_x;
    assign y2 = i_first_end_y;
    assign x3 = i_second_start_x;
    assign y3 = i_second_start_y;
    assign x4 = i_second_end_x;
    assign y4 = i_second_end_y;

    always_comb begin
        if (lex_cmp(x1, y1, x2, y2) == LEX_GT) begin
            lo1x = x2; lo1y = y2; hi1x = x1; hi1y = y1;
        end else begin
            lo1x = x1; lo1y = y1; hi1x = x2; hi1y = y2;
        end
        if (lex_cmp(x3, y3, x4, y4) == LEX_GT) begin
            lo2x = x4; lo2y = y4; hi2x = x3; hi2y = y3;
        end else begin
            lo2x = x3; lo2y = y3; hi2x = x4; hi2y = y4;
        end
        if (lex_cmp(lo1x, lo1y, lo2x, lo2y) != LEX_LT) begin
            sx = lo1x; sy = lo1y;
        end else begin
            sx = lo2x; sy = lo2y;
        end
        if (lex_cmp(hi1x, hi1y, hi2x, hi2y) != LEX_GT) begin
            tx = hi1x; ty = hi1y;
        end else begin
            tx = hi2x; ty = hi2y;
        end
        cc = lex_cmp(sx, sy, tx, ty);
    end

    logic signed [CB-1:0]  r1_p [2];
    logic signed [DXW-1:0] r1_d1 [2];
    logic signed [DXW-1:0] r1_dx2, r1_dy2, r1_wx, r1_wy, r1_vx, r1_vy, r1_bx, r1_by;
    logic [CLW-1:0]        r1_col;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_p[0]  <= x1;
            r1_p[1]  <= y1;
            r1_d1[0] <= DXW'(x2) - DXW'(x1);
            r1_d1[1] <= DXW'(y2) - DXW'(y1);
            r1_dx2   <= DXW'(x4) - DXW'(x3);
            r1_dy2   <= DXW'(y4) - DXW'(y3);
            r1_wx    <= DXW'(x3) - DXW'(x1);
            r1_wy    <= DXW'(y3) - DXW'(y1);
            r1_vx    <= DXW'(x4) - DXW'(x1);
            r1_vy    <= DXW'(y4) - DXW'(y1);
            r1_bx    <= DXW'(x2) - DXW'(x3);
            r1_by    <= DXW'(y2) - DXW'(y3);
            r1_col   <= {cc, int_fix(sx), int_fix(sy), tx, ty};
        end
    end

    // stage 2: cross product terms
    logic signed [PW-1:0]  r2_den_a, r2_den_b, r2_tn_a, r2_tn_b, r2_un_a, r2_un_b;
    logic signed [PW-1:0]  r2_c2_a, r2_c2_b, r2_c4_a, r2_c4_b;
    logic signed [CB-1:0]  r2_p [2];
    logic signed [DXW-1:0] r2_d1 [2];
    logic [CLW-1:0]        r2_col;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_den_a <= r1_d1[0] * r1_dy2;
            r2_den_b <= r1_d1[1] * r1_dx2;
            r2_tn_a  <= r1_wx * r1_dy2;
            r2_tn_b  <= r1_wy * r1_dx2;
            r2_un_a  <= r1_wx * r1_d1[1];
            r2_un_b  <= r1_wy * r1_d1[0];
            r2_c2_a  <= r1_d1[0] * r1_vy;
            r2_c2_b  <= r1_d1[1] * r1_vx;
            r2_c4_a  <= r1_dx2 * r1_by;
            r2_c4_b  <= r1_dy2 * r1_bx;
            r2_p     <= r1_p;
            r2_d1    <= r1_d1;
            r2_col   <= r1_col;
        end
    end

    // stage 3: determinant, parameters, collinear flag
    logic signed [DNW-1:0] r3_den, r3_tn, r3_un;
    logic                  r3_coll;
    logic signed [CB-1:0]  r3_p [2];
    logic signed [DXW-1:0] r3_d1 [2];
    logic [CLW-1:0]        r3_col;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_den  <= DNW'(r2_den_a) - DNW'(r2_den_b);
            r3_tn   <= DNW'(r2_tn_a) - DNW'(r2_tn_b);
            r3_un   <= DNW'(r2_un_a) - DNW'(r2_un_b);
            r3_coll <= (r2_tn_a == r2_tn_b) && (r2_un_a == r2_un_b) &&
                       (r2_c2_a == r2_c2_b) && (r2_c4_a == r2_c4_b);
            r3_p    <= r2_p;
            r3_d1   <= r2_d1;
            r3_col  <= r2_col;
        end
    end

    // stage 4: classify
    logic signed [DNW-1:0] den_s, tn_s, un_s;
    logic                  hit;
    t_lex                  col_lex;
    logic [31:0]           col_px, col_py;
    logic signed [CB-1:0]  col_tx, col_ty;
    t_outcome              outc;
    logic [31:0]           s_px, s_py;
    logic [CB-1:0]         s_ex, s_ey;

    assign col_lex = t_lex'(r3_col[CLW-1 -: 2]);
    assign col_px  = r3_col[CLW-3 -: 32];
    assign col_py  = r3_col[CLW-35 -: 32];
    assign col_tx  = r3_col[2*CB-1 -: CB];
    assign col_ty  = r3_col[CB-1:0];

    always_comb begin
        den_s = r3_den[DNW-1] ? -r3_den : r3_den;
        tn_s  = r3_den[DNW-1] ? -r3_tn  : r3_tn;
        un_s  = r3_den[DNW-1] ? -r3_un  : r3_un;
        hit   = !tn_s[DNW-1] && (tn_s <= den_s) && !un_s[DNW-1] && (un_s <= den_s);
        outc  = OUT_NONE;
        s_px  = '0;
        s_py  = '0;
        s_ex  = '0;
        s_ey  = '0;
        if (r3_den != '0) begin
            outc = hit ? OUT_CROSS : OUT_OUTSIDE;
        end else if (r3_coll) begin
            case (col_lex)
                LEX_EQ: begin
                    outc = OUT_TOUCH;
                    s_px = col_px;
                    s_py = col_py;
                end
                LEX_LT: begin
                    outc = OUT_OVERLAP;
                    s_px = col_px;
                    s_py = col_py;
                    s_ex = col_tx;
                    s_ey = col_ty;
                end
                default: begin
                    outc = OUT_NONE;
                end
            endcase
        end
    end

    logic [DW-1:0]         r4_den, r4_tn;
    logic signed [CB-1:0]  r4_p [2];
    logic signed [DXW-1:0] r4_d1 [2];
    logic [SW0-1:0]        r4_side;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_den  <= den_s[DW-1:0];
            r4_tn   <= tn_s[DW-1:0];
            r4_p    <= r3_p;
            r4_d1   <= r3_d1;
            r4_side <= {outc, s_px, s_py, s_ex, s_ey};
        end
    end

    // stage 5: partial products of p*den + d*tn
    logic signed [H:0]     dlo_s, dhi_s, tlo_s, thi_s;
    logic signed [PW-1:0]  r5_ph [2];
    logic signed [PW-1:0]  r5_pl [2];
    logic signed [QPW-1:0] r5_dh [2];
    logic signed [QPW-1:0] r5_dl [2];
    logic [DW-1:0]         r5_den;
    logic [SW0-1:0]        r5_side;

    assign dlo_s = {1'b0, r4_den[H-1:0]};
    assign dhi_s = {1'b0, r4_den[DW-1:H]};
    assign tlo_s = {1'b0, r4_tn[H-1:0]};
    assign thi_s = {1'b0, r4_tn[DW-1:H]};

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            for (int l = 0; l < 2; l++) begin
                r5_ph[l] <= r4_p[l] * dhi_s;
                r5_pl[l] <= r4_p[l] * dlo_s;
                r5_dh[l] <= r4_d1[l] * thi_s;
                r5_dl[l] <= r4_d1[l] * tlo_s;
            end
            r5_den  <= r4_den;
            r5_side <= r4_side;
        end
    end

    // stage 6: combine halves
    logic signed [NW-1:0] r6_a [2];
    logic signed [NW-1:0] r6_b [2];
    logic [DW-1:0]        r6_den;
    logic [SW0-1:0]       r6_side;

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            for (int l = 0; l < 2; l++) begin
                r6_a[l] <= (NW'(r5_ph[l]) <<< H) + NW'(r5_pl[l]);
                r6_b[l] <= (NW'(r5_dh[l]) <<< H) + NW'(r5_dl[l]);
            end
            r6_den  <= r5_den;
            r6_side <= r5_side;
        end
    end

    // stage 7: numerator
    logic signed [NW-1:0] r7_num [2];
    logic [DW-1:0]        r7_den;
    logic [SW0-1:0]       r7_side;

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            for (int l = 0; l < 2; l++) begin
                r7_num[l] <= r6_a[l] + r6_b[l];
            end
            r7_den  <= r6_den;
            r7_side <= r6_side;
        end
    end

    // stage 8: sign and magnitude
    logic [NW-1:0]  mag_full [2];
    logic [MW-1:0]  r8_mag [2];
    logic [1:0]     r8_neg;
    logic [DW-1:0]  r8_den;
    logic [SW0-1:0] r8_side;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            mag_full[l] = r7_num[l][NW-1] ? NW'(-r7_num[l]) : NW'(r7_num[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            for (int l = 0; l < 2; l++) begin
                r8_mag[l] <= mag_full[l][MW-1:0];
                r8_neg[l] <= r7_num[l][NW-1];
            end
            r8_den  <= r7_den;
            r8_side <= r7_side;
        end
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            o_rem[l] = DW'(r8_mag[l][MW-1:H]);
            o_sr[l]  = SRW'(r8_mag[l][H-1:0]) << FRAC_BITS;
        end
    end

    assign o_den  = r8_den;
    assign o_side = {r8_side, r8_neg[0], r8_neg[1]};

endmodule

// File: rtl/segment_intersection_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_2d
// Classifies a pair of integer 2-D segments and reports the crossing point or
// the collinear overlap.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   input    | i_valid / o_ready  | i_first_*, i_second_* endpoints
//   output   | o_valid / i_ready  | o_outcome, o_point_*, o_overlap_end_*
//
// One pair per cycle sustained while the output is not stalled. The pipeline is
// eight front stages, one divider cell per quotient bit, one output register.
// The divider cell chain sets the depth. Reset clears only the valid bits.
// Every stage holds when its successor is full and stalled, so bubbles fill.
// ----------------------------------------------------------------------------
module segment_intersection_2d
    import segint_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_first_start_x,
    input  logic signed [COORD_BITS-1:0] i_first_start_y,
    input  logic signed [COORD_BITS-1:0] i_first_end_x,
    input  logic signed [COORD_BITS-1:0] i_first_end_y,
    input  logic signed [COORD_BITS-1:0] i_second_start_x,
    input  logic signed [COORD_BITS-1:0] i_second_start_y,
    input  logic signed [COORD_BITS-1:0] i_second_end_x,
    input  logic signed [COORD_BITS-1:0] i_second_end_y,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [2:0]                   o_outcome,
    output logic signed [31:0]           o_point_x,
    output logic signed [31:0]           o_point_y,
    output logic signed [COORD_BITS-1:0] o_overlap_end_x,
    output logic signed [COORD_BITS-1:0] o_overlap_end_y
);

    localparam int CB  = COORD_BITS;
    localparam int DW  = 2*CB+2;
    localparam int QW  = CB+1+FRAC_BITS;
    localparam int SW  = 2*CB+69;

    function automatic logic [31:0] sat_q(input logic neg, input logic [QW-1:0] q);
        logic [63:0] qq;
        logic [63:0] nq;
        logic [31:0] res;
        qq = 64'(q);
        nq = 64'd0 - qq;
        if (neg) begin
            res = (qq > 64'h8000_0000) ? PT_MIN : nq[31:0];
        end else begin
            res = (qq > 64'h7FFF_FFFF) ? PT_MAX : qq[31:0];
        end
        return res;
    endfunction

    logic                  c_valid [QW+1];
    logic                  c_ready [QW+1];
    logic [DW-1:0]         c_den   [QW+1];
    logic [1:0][DW-1:0]    c_rem   [QW+1];
    logic [1:0][QW-1:0]    c_sr    [QW+1];
    logic [1:0][QW-1:0]    c_q     [QW+1];
    logic [SW-1:0]         c_side  [QW+1];

    logic out_en;

    segint_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_first_start_x  (i_first_start_x),
        .i_first_start_y  (i_first_start_y),
        .i_first_end_x    (i_first_end_x),
        .i_first_end_y    (i_first_end_y),
        .i_second_start_x (i_second_start_x),
        .i_second_start_y (i_second_start_y),
        .i_second_end_x   (i_second_end_x),
        .i_second_end_y   (i_second_end_y),
        .o_valid          (c_valid[0]),
        .i_ready          (c_ready[0]),
        .o_den            (c_den[0]),
        .o_rem            (c_rem[0]),
        .o_sr             (c_sr[0]),
        .o_side           (c_side[0])
    );

    assign c_q[0] = '0;

    genvar gc;
    for (gc = 0; gc < QW; gc++) begin : g_cell
        segint_cell #(
            .COORD_BITS (COORD_BITS),
            .FRAC_BITS  (FRAC_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[gc]),
            .o_ready (c_ready[gc]),
            .o_valid (c_valid[gc+1]),
            .i_ready (c_ready[gc+1]),
            .i_den   (c_den[gc]),
            .i_rem   (c_rem[gc]),
            .i_sr    (c_sr[gc]),
            .i_q     (c_q[gc]),
            .i_side  (c_side[gc]),
            .o_den   (c_den[gc+1]),
            .o_rem   (c_rem[gc+1]),
            .o_sr    (c_sr[gc+1]),
            .o_q     (c_q[gc+1]),
            .o_side  (c_side[gc+1])
        );
    end

    // unpack sideband
    t_outcome        f_outcome;
    logic [31:0]     f_px, f_py;
    logic [CB-1:0]   f_ex, f_ey;
    logic            f_negx, f_negy;

    assign f_outcome = t_outcome'(c_side[QW][SW-1 -: 3]);
    assign f_px      = c_side[QW][SW-4 -: 32];
    assign f_py      = c_side[QW][SW-36 -: 32];
    assign f_ex      = c_side[QW][2*CB+1 -: CB];
    assign f_ey      = c_side[QW][CB+1 -: CB];
    assign f_negx    = c_side[QW][1];
    assign f_negy    = c_side[QW][0];

    // output register
    logic            r_valid;
    logic [2:0]      r_outcome;
    logic [31:0]     r_px, r_py;
    logic [CB-1:0]   r_ex, r_ey;
    logic [31:0]     n_px, n_py;

    assign out_en      = !r_valid | i_ready;
    assign c_ready[QW] = out_en;

    always_comb begin
        if (f_outcome == OUT_CROSS) begin
            n_px = sat_q(f_negx, c_q[QW][0]);
            n_py = sat_q(f_negy, c_q[QW][1]);
        end else begin
            n_px = f_px;
            n_py = f_py;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_en) begin
            r_valid <= c_valid[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en) begin
            r_outcome <= f_outcome;
            r_px      <= n_px;
            r_py      <= n_py;
            r_ex      <= f_ex;
            r_ey      <= f_ey;
        end
    end

    assign o_valid         = r_valid;
    assign o_outcome       = r_outcome;
    assign o_point_x       = r_px;
    assign o_point_y       = r_py;
    assign o_overlap_end_x = r_ex;
    assign o_overlap_end_y = r_ey;

endmodule

// File: test/segment_intersection_2d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_2d_checker
// Watches both channels of the segment intersection block. For each accepted
// segment pair it computes the expected classification, crossing point and
// overlap with exact integer arithmetic. Each result beat is compared field
// by field with the oldest expected result.
// ----------------------------------------------------------------------------
module segment_intersection_2d_checker
    import segint_pkg::*;
#(
    parameter int CB = COORD_BITS_DEF,
    parameter int FB = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic signed [CB-1:0] i_x1,
    input  logic signed [CB-1:0] i_y1,
    input  logic signed [CB-1:0] i_x2,
    input  logic signed [CB-1:0] i_y2,
    input  logic signed [CB-1:0] i_x3,
    input  logic signed [CB-1:0] i_y3,
    input  logic signed [CB-1:0] i_x4,
    input  logic signed [CB-1:0] i_y4,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [2:0]           i_outcome,
    input  logic signed [31:0]   i_point_x,
    input  logic signed [31:0]   i_point_y,
    input  logic signed [CB-1:0] i_end_x,
    input  logic signed [CB-1:0] i_end_y,
    output int                   o_errors,
    output int                   o_pending
);

    typedef struct packed {
        t_outcome           outcome;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [CB-1:0]      ex;
        logic [CB-1:0]      ey;
    } t_verdict;

    t_verdict verdicts[$];
    int errors = 0;

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return PT_MAX;
        if (v < -64'sd2147483648) return PT_MIN;
        return v[31:0];
    endfunction

    // trunc(num * 2^FB / den), den > 0
    function automatic logic signed [31:0] fix_quot(logic signed [127:0] num,
                                                    logic signed [127:0] den);
        logic signed [127:0] q;
        logic signed [127:0] lim;
        q = (num <<< FB) / den;
        lim = 128'sd2147483647;
        if (q > lim) return PT_MAX;
        if (q < -lim - 1) return PT_MIN;
        return q[31:0];
    endfunction

    function automatic logic lex_gt(longint ax, longint ay, longint bx, longint by);
        return (ax != bx) ? (ax > bx) : (ay > by);
    endfunction

    function automatic t_verdict classify_pair(longint x1, longint y1, longint x2,
                                               longint y2, longint x3, longint y3,
                                               longint x4, longint y4);
        t_verdict v;
        longint dx1, dy1, dx2, dy2, wx, wy, den, tn, un;
        longint l1x, l1y, h1x, h1y, l2x, l2y, h2x, h2y, sx, sy, tx, ty;
        v = '0;
        v.outcome = OUT_NONE;
        dx1 = x2 - x1; dy1 = y2 - y1; dx2 = x4 - x3; dy2 = y4 - y3;
        wx = x3 - x1; wy = y3 - y1;
        den = dx1 * dy2 - dy1 * dx2;
        if (den != 0) begin
            tn = wx * dy2 - wy * dx2;
            un = wx * dy1 - wy * dx1;
            if (den < 0) begin
                den = -den; tn = -tn; un = -un;
            end
            if (tn >= 0 && tn <= den && un >= 0 && un <= den) begin
                v.outcome = OUT_CROSS;
                v.px = fix_quot(128'(x1) * den + 128'(dx1) * tn, 128'(den));
                v.py = fix_quot(128'(y1) * den + 128'(dy1) * tn, 128'(den));
            end else begin
                v.outcome = OUT_OUTSIDE;
            end
        end else if (dx1 * wy - dy1 * wx == 0 &&
                     dx1 * (y4 - y1) - dy1 * (x4 - x1) == 0 &&
                     dx2 * (y1 - y3) - dy2 * (x1 - x3) == 0 &&
                     dx2 * (y2 - y3) - dy2 * (x2 - x3) == 0) begin
            l1x = x1; l1y = y1; h1x = x2; h1y = y2;
            if (lex_gt(x1, y1, x2, y2)) begin
                l1x = x2; l1y = y2; h1x = x1; h1y = y1;
            end
            l2x = x3; l2y = y3; h2x = x4; h2y = y4;
            if (lex_gt(x3, y3, x4, y4)) begin
                l2x = x4; l2y = y4; h2x = x3; h2y = y3;
            end
            if (lex_gt(l2x, l2y, l1x, l1y)) begin
                sx = l2x; sy = l2y;
            end else begin
                sx = l1x; sy = l1y;
            end
            if (lex_gt(h1x, h1y, h2x, h2y)) begin
                tx = h2x; ty = h2y;
            end else begin
                tx = h1x; ty = h1y;
            end
            if (sx == tx && sy == ty) begin
                v.outcome = OUT_TOUCH;
                v.px = clamp32(sx * (64'sd1 <<< FB));
                v.py = clamp32(sy * (64'sd1 <<< FB));
            end else if (lex_gt(tx, ty, sx, sy)) begin
                v.outcome = OUT_OVERLAP;
                v.px = clamp32(sx * (64'sd1 <<< FB));
                v.py = clamp32(sy * (64'sd1 <<< FB));
                v.ex = tx[CB-1:0];
                v.ey = ty[CB-1:0];
            end
        end
        return v;
    endfunction

    assign o_pending = verdicts.size();
    assign o_errors  = errors;

    always @(posedge i_clk) begin
        t_verdict e;
        if (i_rst_n && i_in_valid && i_in_ready)
            verdicts.push_back(classify_pair(i_x1, i_y1, i_x2, i_y2,
                                             i_x3, i_y3, i_x4, i_y4));
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (verdicts.size() == 0) begin
                $display("%0t: unexpected result beat outcome=%0d", $time, i_outcome);
                errors <= errors + 1;
            end else begin
                e = verdicts.pop_front();
                if (i_outcome !== e.outcome || i_point_x !== e.px ||
                    i_point_y !== e.py || i_end_x !== e.ex || i_end_y !== e.ey) begin
                    $display("%0t: mismatch expected %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                             $time, e.outcome, e.px, e.py, $signed(e.ex), $signed(e.ey),
                             i_outcome, i_point_x, i_point_y, i_end_x, i_end_y);
                    errors <= errors + 1;
                end
            end
        end
    end

endmodule

// File: test/segment_intersection_2d_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_2d_test
// Drives directed and random segment pairs into the intersection block with
// random gaps and output stalls, including a long output hold-off and a full
// drain, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module segment_intersection_2d_test;
    import segint_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int LATENCY = CB + FB + 10;
    localparam int N_RANDOM = 1460;
    localparam int WATCHDOG = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic o_ready, o_valid;
    logic signed [CB-1:0] c[8] = '{default: '0};
    logic [2:0] o_outcome;
    logic signed [31:0] o_point_x, o_point_y;
    logic signed [CB-1:0] o_overlap_end_x, o_overlap_end_y;
    int errors, pending;
    int idle_cycles = 0;
    logic hold_off = 1'b0;
    logic stimulus_done = 1'b0;

    always #6 i_clk = ~i_clk;

    segment_intersection_2d dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_first_start_x(c[0]), .i_first_start_y(c[1]),
        .i_first_end_x(c[2]), .i_first_end_y(c[3]),
        .i_second_start_x(c[4]), .i_second_start_y(c[5]),
        .i_second_end_x(c[6]), .i_second_end_y(c[7]),
        .o_valid, .i_ready, .o_outcome, .o_point_x, .o_point_y,
        .o_overlap_end_x, .o_overlap_end_y
    );

    segment_intersection_2d_checker #(.CB(CB), .FB(FB)) u_checker (
        .i_clk, .i_rst_n, .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_x1(c[0]), .i_y1(c[1]), .i_x2(c[2]), .i_y2(c[3]),
        .i_x3(c[4]), .i_y3(c[5]), .i_x4(c[6]), .i_y4(c[7]),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_outcome(o_outcome),
        .i_point_x(o_point_x), .i_point_y(o_point_y),
        .i_end_x(o_overlap_end_x), .i_end_y(o_overlap_end_y),
        .o_errors(errors), .o_pending(pending)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [CB-1:0] rnd_coord(int span);
        if (span == 0) return CB'($urandom);
        return CB'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic send_pair(input logic signed [CB-1:0] p[8]);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        for (int k = 0; k < 8; k++) c[k] <= p[k];
        do @(posedge i_clk); while (!o_ready);
    endtask

    // stop offering and wait until every expected result has come
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
    endtask

    task automatic send_random();
        logic signed [CB-1:0] p[8];
        int kind, span, tt, a, b;
        logic signed [CB-1:0] bx, by, sx, sy;
        kind = $urandom_range(0, 9);
        span = ($urandom_range(0, 3) == 0) ? 0 : (1 << $urandom_range(2, 12));
        for (int k = 0; k < 8; k++) p[k] = rnd_coord(span);
        if (kind >= 6) begin
            // put all four points on one line through a base point
            sx = CB'($signed(4'($urandom))); sy = CB'($signed(4'($urandom)));
            if (kind == 9) sy = 0;
            bx = rnd_coord(1000); by = rnd_coord(1000);
            for (int k = 0; k < 4; k++) begin
                tt = $signed($urandom_range(0, 40)) - 20;
                p[2*k] = CB'(bx + tt * sx);
                p[2*k+1] = CB'(by + tt * sy);
            end
            if ($urandom_range(0, 5) == 0) begin
                a = $urandom_range(0, 1) * 4;
                p[a+2] = p[a]; p[a+3] = p[a+1];
            end
            if ($urandom_range(0, 5) == 0) begin
                a = $urandom_range(0, 1) * 4; b = 4 - a;
                p[a+2] = p[b+$urandom_range(0,1)*2];
                p[a+3] = p[a+2] == p[b] ? p[b+1] : p[b+3];
            end
        end
        send_pair(p);
    endtask

    initial begin
        logic signed [CB-1:0] d[8];
        logic signed [CB-1:0] mx, mn;
        mx = {1'b0, {(CB-1){1'b1}}};
        mn = {1'b1, {(CB-1){1'b0}}};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        d = '{0, 0, 4, 4, 0, 4, 4, 0}; send_pair(d);
        d = '{0, 0, 1, 1, 0, 3, 3, 0}; send_pair(d);
        d = '{0, 0, 1, 2, 1, 0, 0, 1}; send_pair(d);
        d = '{0, 0, 2, 2, 2, 2, 5, 5}; send_pair(d);
        d = '{0, 0, 4, 4, 6, 6, 2, 2}; send_pair(d);
        d = '{0, 0, 1, 1, 3, 3, 5, 5}; send_pair(d);
        d = '{0, 0, 4, 0, 0, 1, 4, 1}; send_pair(d);
        d = '{3, 3, 3, 3, 0, 0, 6, 6}; send_pair(d);
        d = '{3, 4, 3, 4, 0, 0, 6, 6}; send_pair(d);
        d = '{7, 7, 7, 7, 7, 7, 7, 7}; send_pair(d);
        d = '{5, 0, 5, 9, 5, 3, 5, 2}; send_pair(d);
        d = '{mn, mn, mx, mx, mn, mx, mx, mn}; send_pair(d);
        d = '{mx, mx, mn, mn, mx, mx, mn, mn}; send_pair(d);
        d = '{mn, mn, mn, mx, mx, mn, mx, mx}; send_pair(d);
        d = '{mn, 0, mx, 1, mn, 1, mx, 0}; send_pair(d);
        d = '{mx, mn, mn, mx, mn, mn, mx, mx}; send_pair(d);
        d = '{-1, -1, 0, 0, -1, 0, 0, -1}; send_pair(d);
        d = '{0, 0, 3, 1, 0, 1, 3, 0}; send_pair(d);
        d = '{0, 0, -3, 1, 0, 1, -3, 0}; send_pair(d);
        hold_off <= 1'b1;
        for (int n = 0; n < 120; n++) send_random();
        hold_off <= 1'b0;
        drain();
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) drain();
            send_random();
        end
        i_valid <= 1'b0;
        stimulus_done <= 1'b1;
    end

    // receiver: random stalls, one long hold-off while inputs keep coming
    initial begin
        int g;
        logic held;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_off && !held) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (10 * LATENCY) @(posedge i_clk);
            end
            g = gap_len();
            i_ready <= (g == 0);
            repeat (g > 0 ? g : $urandom_range(1, 8)) @(posedge i_clk);
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG);
        $display("FAILURE");
        $finish;
    end

    initial begin
        wait (stimulus_done && pending == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
